// ===== hw/rtl/fpdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_pkg
// Shared constants and types of the fixed-point decimal formatter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

	localparam int VALUE_BITS = 32;
	localparam int DIGITS     = 10;
	localparam int BCD_BITS   = 4 * DIGITS;
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int IDX_W      = $clog2(DIGITS);
	localparam int PLACES_W   = 4;
	localparam int CHAR_W     = 7;

	localparam logic [PLACES_W-1:0] MAX_PLACES = 4'd9;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;

	typedef logic [DIGITS-1:0][3:0] bcd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} conv_stat_t;

	typedef struct packed {
		logic busy;
		logic finish;
	} seq_stat_t;

	typedef struct packed {
		logic             neg;
		logic [IDX_W-1:0] places;
	} seq_ctrl_t;

endpackage

// ===== hw/rtl/fpdf_bcd_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_bcd_conv
// Iterative binary to BCD converter, one shift-and-adjust step per cycle.
// ----------------------------------------------------------------------------
module fpdf_bcd_conv (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [fpdf_pkg::VALUE_BITS-1:0]  mag,
	output fpdf_pkg::conv_stat_t             stat,
	output fpdf_pkg::bcd_t                   digits
);
	import fpdf_pkg::*;

	logic [VALUE_BITS-1:0] shift_q;
	bcd_t                  bcd_q;
	bcd_t                  adj;
	logic [BCD_BITS:0]     bcd_shift;
	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;

	// add 3 to every digit of five or more
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	assign bcd_shift = {adj, shift_q[VALUE_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			bcd_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else if (start) begin
			shift_q <= mag;
			bcd_q   <= '0;
			cnt_q   <= CNT_W'(VALUE_BITS);
			done_q  <= 1'b0;
		end else if (cnt_q != '0) begin
			shift_q <= shift_q << 1;
			bcd_q   <= bcd_shift[BCD_BITS-1:0];
			cnt_q   <= cnt_q - 1'b1;
			done_q  <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign digits    = bcd_q;

endmodule

// ===== hw/rtl/fpdf_char_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_char_seq
// Character sequencer: sign, integer digits, point and fraction digits.
// ----------------------------------------------------------------------------
module fpdf_char_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  fpdf_pkg::seq_ctrl_t              ctrl,
	input  fpdf_pkg::bcd_t                   digits,
	output logic [fpdf_pkg::CHAR_W-1:0]      char_code,
	output logic                             last_char,
	output logic                             char_valid,
	input  logic                             char_stall,
	output fpdf_pkg::seq_stat_t              stat
);
	import fpdf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   places_q;
	logic [IDX_W-1:0]   first_idx;
	logic               sign_pend_q;
	logic               dot_pend_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               valid_q;
	logic               can_load;
	logic               emit_load;
	logic               finish;

	// highest nonzero integer digit, else the units digit
	always_comb begin
		first_idx = places_q;
		for (int i = 0; i < DIGITS; i++) begin
			if (IDX_W'(i) >= places_q && digits[i] != 4'd0) begin
				first_idx = IDX_W'(i);
			end
		end
	end

	assign can_load  = !valid_q || !char_stall;
	assign emit_load = (state_q == S_EMIT) && can_load;
	assign finish    = (state_q == S_EMIT) && can_load && !sign_pend_q && !dot_pend_q
		&& (idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= 1'b0;
			sign_pend_q <= 1'b0;
			dot_pend_q  <= 1'b0;
			idx_q       <= '0;
			places_q    <= '0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit_load) begin
				valid_q <= 1'b1;
			end else if (!char_stall) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q     <= S_FIND;
						sign_pend_q <= ctrl.neg;
						places_q    <= ctrl.places;
						dot_pend_q  <= 1'b0;
					end
				end
				S_FIND: begin
					idx_q   <= first_idx;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (can_load) begin
						if (sign_pend_q) begin
							char_q      <= CHAR_MINUS;
							last_q      <= 1'b0;
							sign_pend_q <= 1'b0;
						end else if (dot_pend_q) begin
							char_q     <= CHAR_DOT;
							last_q     <= 1'b0;
							dot_pend_q <= 1'b0;
						end else begin
							char_q <= CHAR_ZERO + {3'b000, digits[idx_q]};
							last_q <= (idx_q == '0);
							if (idx_q == '0) begin
								state_q <= S_IDLE;
							end else begin
								idx_q      <= idx_q - 1'b1;
								dot_pend_q <= (idx_q == places_q);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign char_code   = char_q;
	assign last_char   = last_q;
	assign char_valid  = valid_q;
	assign stat.busy   = (state_q != S_IDLE);
	assign stat.finish = finish;

endmodule

// ===== hw/rtl/fixed_point_decimal_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter
// Signed fixed-point value to decimal ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// after the input transfer the BCD unit runs 32 shift-and-adjust steps;
// then the sequencer emits 1..12 characters, one per cycle unless
// char_stall holds it; value_stall stays high until the last character loads
// reset: asynchronous, clears busy, sequencer state and output valid
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [31:0]                  value,
	input  logic [fpdf_pkg::PLACES_W-1:0]       decimal_places,
	input  logic                                value_valid,
	output logic                                value_stall,
	output logic [fpdf_pkg::CHAR_W-1:0]         char_code,
	output logic                                last_char,
	output logic                                char_valid,
	input  logic                                char_stall
);
	import fpdf_pkg::*;

	logic                  busy_q;
	logic                  accept;
	logic [VALUE_BITS-1:0] raw;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;
	logic [PLACES_W-1:0]   places_sat;
	seq_ctrl_t             ctrl_q;
	conv_stat_t            cstat;
	seq_stat_t             sstat;
	bcd_t                  digits;

	assign accept     = value_valid && !value_stall;
	assign raw        = value[VALUE_BITS-1:0];
	assign neg        = raw[VALUE_BITS-1];
	assign mag        = neg ? (~raw + 1'b1) : raw;
	assign places_sat = (decimal_places > MAX_PLACES) ? MAX_PLACES : decimal_places;
	assign value_stall = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (sstat.finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_q.neg    <= neg;
			ctrl_q.places <= IDX_W'(places_sat);
		end
	end

	fpdf_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.stat   (cstat),
		.digits (digits)
	);

	fpdf_char_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cstat.done),
		.ctrl       (ctrl_q),
		.digits     (digits),
		.char_code  (char_code),
		.last_char  (last_char),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.stat       (sstat)
	);

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !cstat.busy && !sstat.busy)
		else $error("units active while not busy");

	a_conv_seq_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cstat.done |-> !sstat.busy)
		else $error("conversion finished while sequencer active");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		sstat.finish |=> char_valid && last_char)
		else $error("final character not presented");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> char_code == CHAR_MINUS || char_code == CHAR_DOT
			|| (char_code >= CHAR_ZERO && char_code <= CHAR_NINE))
		else $error("illegal character code");

endmodule
